// File: sv/hashed_key_cache_lookup_insert_core_defines.svh
// Assertion macros used by the datapath RTL of the key cache.
`ifndef HASHED_KEY_CACHE_LOOKUP_INSERT_CORE_DEFINES_SVH
`define HASHED_KEY_CACHE_LOOKUP_INSERT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define HKC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// Check a property on every clock edge, reset included.
`define HKC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);
`else
`define HKC_ASSERT(lbl, prop, msg)
`define HKC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: sv/hkc_pkg.sv
`timescale 1ns / 1ps

package hkc_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int KEY_BITS      = 32;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam bit IS_POW2       = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);

  localparam logic [31:0] HASH_MULT  = 32'd2654435761;
  // floor(2^32 / TABLE_ENTRIES), the reciprocal for the non power of two modulo
  localparam logic [31:0] HASH_RECIP = 32'((64'd1 << 32) / TABLE_ENTRIES);
  localparam logic        KIND_CLEAR = 1'b1;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [IDX_W-1:0]    idx_t;

  typedef enum logic [1:0] {
    ST_HIT   = 2'd0,
    ST_NEW   = 2'd1,
    ST_FULL  = 2'd2,
    ST_CLEAR = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MULT,
    S_DIV,
    S_START,
    S_PROBE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic mult;
    logic div_step;
    logic start;
    logic probe;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic hit;
    logic empty;
    logic last_probe;
    logic out_free;
  } dp_sts_t;

  // Keep the low KEY_BITS bits of the 32-bit key field, zero-extend above.
  function automatic key_t mask_key(input logic [31:0] k);
    logic [63:0] w;
    w = 64'(k);
    return w[KEY_BITS-1:0];
  endfunction

endpackage

// File: sv/hkc_ram.sv
`timescale 1ns / 1ps

module hkc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/hkc_ctrl.sv
`timescale 1ns / 1ps

module hkc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_kind,
  output logic              in_tready,
  input  hkc_pkg::dp_sts_t  sts,
  output hkc_pkg::ctl_cmd_t cmd
);

  import hkc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (in_kind == KIND_CLEAR) ? S_DONE : S_MULT;
        end
      end
      S_MULT:  state_nxt = IS_POW2 ? S_START : S_DIV;
      S_DIV:   if (sts.div_last) state_nxt = S_START;
      S_START: state_nxt = S_PROBE;
      S_PROBE: begin
        if (sts.hit || sts.empty || sts.last_probe) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE:  if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_CLEAR: cmd.clr_wr = 1'b1;
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_MULT:  cmd.mult     = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_START: cmd.start    = 1'b1;
      S_PROBE: cmd.probe    = 1'b1;
      S_DONE:  cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: sv/hkc_datapath.sv
`timescale 1ns / 1ps
`include "hashed_key_cache_lookup_insert_core_defines.svh"

module hkc_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic [31:0]       in_tdata,
  input  logic              in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [39:0]       out_tdata,
  output logic [1:0]        out_tuser,
  input  hkc_pkg::ctl_cmd_t cmd,
  output hkc_pkg::dp_sts_t  sts
);

  import hkc_pkg::*;

  localparam idx_t LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // control registers
  logic        cen_r;
  idx_t        clr_cnt_r;
  logic        out_valid_r;
  logic [31:0] miss_r, miss_nxt;

  // payload registers
  key_t           key_r;
  logic [31:0]    prod_r;
  logic [31:0]    quot_r;
  logic           div_ph_r;
  logic [IDX_W:0] rem_r, rem_nxt;
  idx_t           idx_r, probes_r;
  status_t        res_status_r;
  logic [7:0]     res_slot_r;
  status_t        out_status_r;
  logic [7:0]     out_slot_r;

  logic [63:0]    key_wide;
  logic [31:0]    key32;
  logic [31:0]    prod_full;
  logic [63:0]    recip_prod;
  logic [31:0]    back_prod;
  logic [31:0]    rem_est;
  logic [IDX_W:0] rem_fix;
  idx_t           hash_idx, idx_next, rd_addr;
  logic [31:0]    idx_wide;
  logic           used_rd;
  key_t           key_rd;
  logic           ins_wr;
  logic           used_wr_en;
  idx_t           used_wr_addr;
  logic           bump;

  assign key_wide  = 64'(key_r);
  assign key32     = key_wide[31:0];
  assign prod_full = key32 * HASH_MULT;

  // modulo by reciprocal: the quotient estimate is low by at most one, so
  // one compare and subtract finishes the remainder
  assign recip_prod = 64'(prod_r) * 64'(HASH_RECIP);
  assign back_prod  = quot_r * 32'(TABLE_ENTRIES);
  assign rem_est    = prod_r - back_prod;
  assign rem_nxt    = rem_est[IDX_W:0];
  assign rem_fix    = (rem_r >= (IDX_W+1)'(TABLE_ENTRIES))
                    ? rem_r - (IDX_W+1)'(TABLE_ENTRIES) : rem_r;

  assign hash_idx = IS_POW2 ? prod_r[IDX_W-1:0] : rem_fix[IDX_W-1:0];
  assign idx_next = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
  assign idx_wide = 32'(idx_r);

  // read the next slot ahead while the current one is compared
  assign rd_addr = cmd.start ? hash_idx : idx_next;

  assign sts.clr_last   = (clr_cnt_r == LAST_IDX);
  assign sts.div_last   = div_ph_r;
  assign sts.hit        = used_rd && (key_rd == key_r);
  assign sts.empty      = !used_rd;
  assign sts.last_probe = (probes_r == LAST_IDX);
  assign sts.out_free   = !out_valid_r || out_tready;

  assign ins_wr       = cmd.probe && !used_rd;
  assign used_wr_en   = cmd.clr_wr || ins_wr;
  assign used_wr_addr = cmd.clr_wr ? clr_cnt_r : idx_r;

  hkc_ram #(.WIDTH(1), .DEPTH(TABLE_ENTRIES)) u_used_ram (
    .clk     (clk),
    .wr_en   (used_wr_en),
    .wr_addr (used_wr_addr),
    .wr_data (!cmd.clr_wr),
    .rd_en   (cmd.start || cmd.probe),
    .rd_addr (rd_addr),
    .rd_data (used_rd)
  );

  hkc_ram #(.WIDTH(KEY_BITS), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk     (clk),
    .wr_en   (ins_wr),
    .wr_addr (idx_r),
    .wr_data (key_r),
    .rd_en   (cmd.start || cmd.probe),
    .rd_addr (rd_addr),
    .rd_data (key_rd)
  );

  assign bump = ((res_status_r == ST_NEW) || (res_status_r == ST_FULL))
             && cen_r && (miss_r != '1);

  always_comb begin
    miss_nxt = miss_r;
    if (res_status_r == ST_CLEAR) begin
      miss_nxt = '0;
    end else if (bump) begin
      miss_nxt = miss_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cen_r       <= 1'b0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      miss_r      <= '0;
    end else begin
      if (cfg_wr_en) cen_r <= cfg_wr_data;
      if (cmd.clr_wr) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
        miss_r      <= miss_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r        <= mask_key(in_tdata);
      res_status_r <= (in_tuser == KIND_CLEAR) ? ST_CLEAR : ST_HIT;
      res_slot_r   <= '0;
    end
    if (cmd.mult) begin
      prod_r   <= prod_full;
      div_ph_r <= 1'b0;
    end
    if (cmd.div_step) begin
      if (div_ph_r) begin
        rem_r <= rem_nxt;
      end else begin
        quot_r <= recip_prod[63:32];
      end
      div_ph_r <= 1'b1;
    end
    if (cmd.start) begin
      idx_r    <= hash_idx;
      probes_r <= '0;
    end
    if (cmd.probe) begin
      if (sts.hit) begin
        res_status_r <= ST_HIT;
        res_slot_r   <= idx_wide[7:0];
      end else if (sts.empty) begin
        res_status_r <= ST_NEW;
        res_slot_r   <= idx_wide[7:0];
      end else if (sts.last_probe) begin
        res_status_r <= ST_FULL;
        res_slot_r   <= '0;
      end else begin
        idx_r    <= idx_next;
        probes_r <= probes_r + 1'b1;
      end
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {miss_r, out_slot_r};
  assign out_tuser  = out_status_r;

  `HKC_ASSERT(a_clear_zeroes, cmd.out_load && (res_status_r == ST_CLEAR) |=> miss_r == '0, "clear item left miss counter nonzero")
  `HKC_ASSERT(a_hit_keeps, cmd.out_load && (res_status_r == ST_HIT) |=> miss_r == $past(miss_r), "hit changed miss counter")
  `HKC_ASSERT(a_full_slot, cmd.out_load && (res_status_r == ST_FULL) |=> out_slot_r == '0, "full result with nonzero slot")
  `HKC_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_valid_r, "result valid right after reset")

endmodule

// File: sv/hashed_key_cache_lookup_insert_core.sv
`timescale 1ns / 1ps
// Channel   Direction  tdata (low bit up)          tuser
// in_       slave      key[31:0]                   kind (1 = clear miss counter)
// out_      master     slot[7:0], miss_count[39:8] status[1:0]
// cfg_      write      count_enable in cfg_wr_data -
//
// Lookup: accept, hash multiply, probe start, a probe walk over P slots
//   (1 to TABLE_ENTRIES), then result load; the used and key RAM read port
//   walks one slot per cycle. A table size that is not a power of two adds a
//   reciprocal modulo step. Clear item: accept, then result load.
// One item is in flight at a time. Reset: a clearing pass over the used RAM
//   writes every slot with in_tready low; config writes are taken throughout.
// Stalls: a result waits in the output register; the next item is accepted
//   meanwhile and holds in its final cycle until the register frees.

module hashed_key_cache_lookup_insert_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // key[31:0]
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // slot[7:0], miss_count[39:8]
  output logic [1:0]  out_tuser   // status
);

  import hkc_pkg::*;

  // command and status between the sequencer and the datapath
  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // Sequencer: reset sweep, accept, hash, probe walk, result hand-off.
  hkc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: hash multiplier, probe index, table RAMs, counter, output register.
  hkc_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule
